FILE: src/plrc_pkg.sv
package plrc_pkg;

  // Table geometry and number formats
  localparam int MAX_POINTS = 16;
  localparam int ADC_BITS   = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int OHMS_W     = 32;

  // Signed numerator: two products of a 33-bit and an (ADC_BITS+1)-bit operand, summed
  localparam int ACC_W  = OHMS_W + ADC_BITS + 2;
  localparam int MAG_W  = ACC_W - 1;
  localparam int DCNT_W = $clog2(MAG_W);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PASS_LIMIT  = REG_IDX_W'(1);

  // Request command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SCAN,
    OP_FETCH0,
    OP_FETCH1,
    OP_FETCH2,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_DIVINIT,
    OP_DIV,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } plrc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic skip_div;
    logic div_last;
    logic out_free;
  } plrc_stat_t;

endpackage

FILE: src/piecewise_linear_resistance_calibration.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | command, point_index, point_code, point_ohms,
//         |           |                     | adc_code
// out_    | output    | out_valid/out_ready | resistance_ohms, below_limit, extrapolated,
//         |           |                     | table_fault
// cfg_    | input     | APB, pready tied 1  | 0x0 point_count, 0x4 pass_limit_ohms
//
// Load request: written into the table, no result.
// Convert request: table scan over the n points in use, segment fetch, multiply,
//   bit-serial divide, then the output register.
//   A faulted segment skips the arithmetic and goes from the fetch to the output.
// Reset (rst_n low, synchronous) clears the controller, output valid and the
//   registers (point_count = 2); the table holds no reset value.
// A held result stalls only the next convert at its final cycle; in_ready is
//   high whenever the controller is idle, also while a result waits.
module piecewise_linear_resistance_calibration import plrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [3:0]            in_point_index,
  input  logic [15:0]           in_point_code,
  input  logic [31:0]           in_point_ohms,
  input  logic [15:0]           in_adc_code,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_resistance_ohms,
  output logic                  out_below_limit,
  output logic                  out_extrapolated,
  output logic                  out_table_fault,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CNT_W-1:0]  point_count;
  logic [OHMS_W-1:0] pass_limit_ohms;
  plrc_cmd_t         cmd;
  plrc_stat_t        stat;

  // Register file: point count and pass limit
  plrc_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .point_count     (point_count),
    .pass_limit_ohms (pass_limit_ohms)
  );

  // Sequencer: table scan, segment fetch, multiply, divide, hand-over
  plrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Table memory, search registers, shared multiplier, divider, output register
  plrc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_point_index      (in_point_index),
    .in_point_code       (in_point_code),
    .in_point_ohms       (in_point_ohms),
    .in_adc_code         (in_adc_code),
    .point_count         (point_count),
    .pass_limit_ohms     (pass_limit_ohms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_resistance_ohms (out_resistance_ohms),
    .out_below_limit     (out_below_limit),
    .out_extrapolated    (out_extrapolated),
    .out_table_fault     (out_table_fault)
  );

endmodule

FILE: src/plrc_regs.sv
module plrc_regs import plrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [CNT_W-1:0]      point_count,
  output logic [OHMS_W-1:0]     pass_limit_ohms
);

  logic [CNT_W-1:0]     point_count_r;
  logic [OHMS_W-1:0]    pass_limit_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(2);
      pass_limit_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POINT_COUNT: point_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_PASS_LIMIT:  pass_limit_r  <= cfg_pwdata[OHMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POINT_COUNT: cfg_prdata = CFG_DATA_W'(point_count_r);
      REG_PASS_LIMIT:  cfg_prdata = CFG_DATA_W'(pass_limit_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign point_count     = point_count_r;
  assign pass_limit_ohms = pass_limit_r;

endmodule

FILE: src/plrc_ctrl.sv
module plrc_ctrl import plrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_command,
  output logic       in_ready,
  input  plrc_stat_t stat,
  output plrc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIVINIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          if (in_command == CMD_LOAD) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op    = OP_START;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) state_nxt = S_FETCH0;
      end
      S_FETCH0: begin
        cmd.op    = OP_FETCH0;
        state_nxt = S_FETCH1;
      end
      S_FETCH1: begin
        cmd.op    = OP_FETCH1;
        state_nxt = S_FETCH2;
      end
      S_FETCH2: begin
        cmd.op    = OP_FETCH2;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        // no usable segment: skip the arithmetic
        if (stat.skip_div) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_MUL0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

  a_skip_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL0 && stat.skip_div) |=> state_r == S_DONE)
    else $error("faulted segment did not bypass divider");

endmodule

FILE: src/plrc_dp.sv
module plrc_dp import plrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  plrc_cmd_t         cmd,
  output plrc_stat_t        stat,
  input  logic [3:0]        in_point_index,
  input  logic [15:0]       in_point_code,
  input  logic [31:0]       in_point_ohms,
  input  logic [15:0]       in_adc_code,
  input  logic [CNT_W-1:0]  point_count,
  input  logic [OHMS_W-1:0] pass_limit_ohms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_resistance_ohms,
  output logic              out_below_limit,
  output logic              out_extrapolated,
  output logic              out_table_fault
);

  // Calibration table, one read port with registered data
  logic [ADC_BITS-1:0] code_mem [MAX_POINTS];
  logic [OHMS_W-1:0]   ohms_mem [MAX_POINTS];
  logic [IDX_W-1:0]    rd_addr;
  logic [ADC_BITS-1:0] rd_code_q;
  logic [OHMS_W-1:0]   rd_ohms_q;

  // Search
  logic [ADC_BITS-1:0] u_r, prev_r, first_code_r;
  logic [CNT_W-1:0]    n_r, n_clamp;
  logic [IDX_W-1:0]    scan_idx_r, seg_r;
  logic                found_r, nofound_r, extra_r;
  logic                match, above_last, at_or_below_first;

  // Arithmetic
  logic [ADC_BITS-1:0]      seg_c0_r;
  logic [OHMS_W-1:0]        seg_r0_r;
  logic signed [ADC_BITS:0] den_r, du_r, mul_b;
  logic signed [OHMS_W:0]   dr_r, mul_a;
  logic signed [ACC_W-1:0]  prod, prod_r, acc_r;

  // Divider
  logic [MAG_W-1:0]    quo_r;
  logic [ADC_BITS-1:0] rem_r, dsr_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic                neg_r;
  logic [ADC_BITS:0]   trial, trial_diff;
  logic                trial_ge;

  // Result
  logic              fault;
  logic [OHMS_W-1:0] res;
  logic              out_valid_r, below_r, extra_out_r, fault_out_r;
  logic [OHMS_W-1:0] res_r;

  always_comb begin
    if (point_count < CNT_W'(2))                 n_clamp = CNT_W'(2);
    else if (int'(point_count) > MAX_POINTS)     n_clamp = CNT_W'(MAX_POINTS);
    else                                         n_clamp = point_count;
  end

  always_comb begin
    case (cmd.op)
      OP_START:  rd_addr = '0;
      OP_SCAN:   rd_addr = scan_idx_r + IDX_W'(1);
      OP_FETCH0: rd_addr = seg_r;
      OP_FETCH1: rd_addr = seg_r + IDX_W'(1);
      default:   rd_addr = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && int'(in_point_index) < MAX_POINTS) begin
      code_mem[IDX_W'(in_point_index)] <= in_point_code[ADC_BITS-1:0];
      ohms_mem[IDX_W'(in_point_index)] <= in_point_ohms;
    end
    rd_code_q <= code_mem[rd_addr];
    rd_ohms_q <= ohms_mem[rd_addr];
  end

  assign match             = (scan_idx_r != '0) && (u_r > prev_r) && (u_r <= rd_code_q);
  assign above_last        = u_r > rd_code_q;
  assign at_or_below_first = u_r <= first_code_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        u_r        <= in_adc_code[ADC_BITS-1:0];
        n_r        <= n_clamp;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        seg_r      <= '0;
      end
      OP_SCAN: begin
        prev_r     <= rd_code_q;
        scan_idx_r <= scan_idx_r + IDX_W'(1);
        if (scan_idx_r == '0) first_code_r <= rd_code_q;
        if (stat.scan_last) begin
          // last point: apply the end-of-table overrides
          if (above_last)                seg_r <= scan_idx_r - IDX_W'(1);
          else if (at_or_below_first)    seg_r <= '0;
          else if (!found_r && match)    seg_r <= scan_idx_r - IDX_W'(1);
          extra_r   <= (u_r < first_code_r) || above_last;
          nofound_r <= !(above_last || at_or_below_first || found_r || match);
        end else if (match && !found_r) begin
          found_r <= 1'b1;
          seg_r   <= scan_idx_r - IDX_W'(1);
        end
      end
      OP_FETCH1: begin
        seg_c0_r <= rd_code_q;
        seg_r0_r <= rd_ohms_q;
      end
      OP_FETCH2: begin
        den_r <= $signed({1'b0, rd_code_q}) - $signed({1'b0, seg_c0_r});
        du_r  <= $signed({1'b0, u_r}) - $signed({1'b0, seg_c0_r});
        dr_r  <= $signed({1'b0, rd_ohms_q}) - $signed({1'b0, seg_r0_r});
      end
      default: ;
    endcase
  end

  // num = r0*(c1-c0) + (r1-r0)*(u-c0) over one shared multiplier
  always_comb begin
    if (cmd.op == OP_MUL0) begin
      mul_a = $signed({1'b0, seg_r0_r});
      mul_b = den_r;
    end else begin
      mul_a = dr_r;
      mul_b = du_r;
    end
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL0: prod_r <= prod;
      OP_MUL1: begin
        prod_r <= prod;
        acc_r  <= prod_r;
      end
      OP_MUL2: acc_r <= acc_r + prod_r;
      default: ;
    endcase
  end

  // Restoring divide on magnitudes, one quotient bit per cycle
  assign trial      = {rem_r, quo_r[MAG_W-1]};
  assign trial_diff = trial - {1'b0, dsr_r};
  assign trial_ge   = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIVINIT: begin
        neg_r     <= acc_r[ACC_W-1] ^ den_r[ADC_BITS];
        quo_r     <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : acc_r[MAG_W-1:0];
        dsr_r     <= den_r[ADC_BITS] ? ADC_BITS'(-den_r) : den_r[ADC_BITS-1:0];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      OP_DIV: begin
        rem_r     <= trial_ge ? trial_diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
        quo_r     <= {quo_r[MAG_W-2:0], trial_ge};
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
      end
      default: ;
    endcase
  end

  // Faults and negatives give zero, saturate above 32 bits
  assign fault = nofound_r || (den_r == '0);

  always_comb begin
    if (fault || neg_r)                 res = '0;
    else if (|quo_r[MAG_W-1:OHMS_W])   res = '1;
    else                                res = quo_r[OHMS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      res_r       <= res;
      below_r     <= res < pass_limit_ohms;
      extra_out_r <= extra_r;
      fault_out_r <= fault;
    end
  end

  assign stat.scan_last = CNT_W'(scan_idx_r) == (n_r - CNT_W'(1));
  assign stat.skip_div  = fault;
  assign stat.div_last  = div_cnt_r == DCNT_W'(MAG_W - 1);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_resistance_ohms = res_r;
  assign out_below_limit     = below_r;
  assign out_extrapolated    = extra_out_r;
  assign out_table_fault     = fault_out_r;

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fault_out_r) |-> res_r == '0)
    else $error("faulted result not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> stat.out_free)
    else $error("pending result overwritten");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV) |-> dsr_r != '0)
    else $error("divide by zero entered");

endmodule

FILE: tb/tb_piecewise_linear_resistance_calibration.sv
module tb_piecewise_linear_resistance_calibration;
  timeunit 1ns;
  timeprecision 1ps;
  import plrc_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 100; // outlasts the slowest convert
  localparam int LONG_HOLD_CYCLES = 700;
  localparam int IDLE_MAX         = 14;
  localparam longint OHMS_CEIL    = 64'h0000_0000_FFFF_FFFF;

  // One expected reading per convert request
  typedef struct {
    logic [OHMS_W-1:0] ohms;
    logic              below_limit;
    logic              extrapolated;
    logic              table_fault;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_command = CMD_LOAD;
  logic [3:0]            in_point_index = '0;
  logic [15:0]           in_point_code = '0;
  logic [31:0]           in_point_ohms = '0;
  logic [15:0]           in_adc_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [31:0]           out_resistance_ohms;
  logic                  out_below_limit;
  logic                  out_extrapolated;
  logic                  out_table_fault;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the block: registers and calibration table
  logic [CNT_W-1:0]  cfg_count = CNT_W'(2);
  logic [OHMS_W-1:0] cfg_limit = '0;
  logic [15:0]       cal_code [MAX_POINTS];
  logic [31:0]       cal_ohms [MAX_POINTS];

  reading_t pending_readings [$];
  int       failures = 0;
  int       items_accepted = 0;

  // Idling controls, shared by the sender, the receiver and the tests
  bit in_idling = 1'b1;
  bit out_idling = 1'b1;
  bit hold_results_req = 1'b0;

  piecewise_linear_resistance_calibration uut (.*);

  always #6 clk = ~clk;

  // Hard stop, far beyond the slowest legal run
  initial begin
    #24ms;
    $display("piecewise_linear_resistance_calibration regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Point count is clamped to 2..MAX_POINTS by the block
  function automatic int unsigned points_in_use();
    if (cfg_count < 2) return 2;
    if (cfg_count > MAX_POINTS) return MAX_POINTS;
    return cfg_count;
  endfunction

  // Segment search, interpolation with truncation, clamp and saturation
  function automatic reading_t interpolate_resistance(input logic [15:0] adc);
    reading_t     r;
    int unsigned  n;
    int unsigned  seg;
    bit           found;
    longint       u, c0, c1, r0, r1, den, num, q;
    n = points_in_use();
    u = longint'(adc[ADC_BITS-1:0]);
    seg = 0;
    found = 1'b0;
    r.ohms = '0;
    r.extrapolated = 1'b0;
    r.table_fault = 1'b0;
    // first matching segment wins
    for (int unsigned j = 0; j + 1 < n; j++) begin
      if (!found && u > cal_code[j] && u <= cal_code[j+1]) begin
        seg = j;
        found = 1'b1;
      end
    end
    // at or below the first point: first segment
    if (u <= cal_code[0]) begin
      seg = 0;
      found = 1'b1;
      if (u < cal_code[0]) r.extrapolated = 1'b1;
    end
    // above the last point: last segment, overriding the above
    if (u > cal_code[n-1]) begin
      seg = n - 2;
      found = 1'b1;
      r.extrapolated = 1'b1;
    end
    if (!found) begin
      r.table_fault = 1'b1;
    end else begin
      c0 = longint'(cal_code[seg]);
      c1 = longint'(cal_code[seg+1]);
      r0 = longint'(cal_ohms[seg]);
      r1 = longint'(cal_ohms[seg+1]);
      den = c1 - c0;
      if (den == 0) begin
        r.table_fault = 1'b1;
      end else begin
        // signed divisor also covers descending segments
        num = c1 * r0 - c0 * r1 + (r1 - r0) * u;
        q = num / den;
        if (q < 0) r.ohms = '0;
        else if (q > OHMS_CEIL) r.ohms = '1;
        else r.ohms = q[31:0];
      end
    end
    // a fault still compares zero with the limit
    r.below_limit = (r.ohms < cfg_limit);
    return r;
  endfunction

  // Convert codes biased towards the table's points and its span
  function automatic logic [15:0] pick_adc_code();
    int unsigned n;
    n = points_in_use();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: return cal_code[$urandom_range(0, n - 1)];
      3: return cal_code[$urandom_range(0, n - 1)] + 16'($urandom_range(0, 2)) - 16'd1;
      4: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: begin
        if (cal_code[0] < cal_code[n-1])
          return 16'($urandom_range(cal_code[0], cal_code[n-1]));
        return 16'($urandom);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and waits for the handshake. Valid is left high on
  // return; back-to-back requests drop it only for an idle gap while in_idling is set.
  task automatic send_request(input logic cmd, input logic [3:0] idx,
                              input logic [15:0] code, input logic [31:0] ohms,
                              input logic [15:0] adc);
    if (in_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_point_index <= idx;
    in_point_code  <= code;
    in_point_ohms  <= ohms;
    in_adc_code    <= adc;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      if (idx < MAX_POINTS) begin
        cal_code[idx] = code[ADC_BITS-1:0];
        cal_ohms[idx] = ohms;
      end
    end else begin
      pending_readings.push_back(interpolate_resistance(adc));
    end
    items_accepted++;
  endtask

  // Unused fields carry random data so every bit toggles
  task automatic load_point(input logic [3:0] idx, input logic [15:0] code,
                            input logic [31:0] ohms);
    send_request(CMD_LOAD, idx, code, ohms, 16'($urandom));
  endtask

  task automatic convert_code(input logic [15:0] adc);
    send_request(CMD_CONVERT, 4'($urandom), 16'($urandom), $urandom, adc);
  endtask

  // Drop valid, let every reading arrive, then give a trailing load or
  // convert time to finish before the registers are touched
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  task automatic apb_cycle(input logic wr, input logic [REG_IDX_W-1:0] reg_idx,
                           input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] reg_idx,
                                input logic [31:0] value);
    logic [31:0] readback;
    apb_cycle(1'b1, reg_idx, value, readback);
    if (reg_idx == REG_POINT_COUNT) cfg_count = value[CNT_W-1:0];
    else cfg_limit = value;
    apb_cycle(1'b0, reg_idx, '0, readback);
    if (readback !== value) begin
      $error("register %0d readback: expected %0h, got %0h", reg_idx, value, readback);
      failures++;
    end
  endtask

  // Registers only change with the block idle
  task automatic program_registers(input logic [4:0] count_raw, input logic [31:0] limit);
    wait_idle();
    write_register(REG_POINT_COUNT, 32'(count_raw));
    write_register(REG_PASS_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random ready bursts, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_results_req) begin
        hold_results_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (out_idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Each reading is matched against the oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: resistance_ohms %0d", out_resistance_ohms);
        failures++;
      end else begin
        want = pending_readings.pop_front();
        if (out_resistance_ohms !== want.ohms) begin
          $error("resistance_ohms: expected %0d, got %0d", want.ohms, out_resistance_ohms);
          failures++;
        end
        if (out_below_limit !== want.below_limit) begin
          $error("below_limit: expected %0b, got %0b", want.below_limit, out_below_limit);
          failures++;
        end
        if (out_extrapolated !== want.extrapolated) begin
          $error("extrapolated: expected %0b, got %0b", want.extrapolated, out_extrapolated);
          failures++;
        end
        if (out_table_fault !== want.table_fault) begin
          $error("table_fault: expected %0b, got %0b", want.table_fault, out_table_fault);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every slot gets written before any convert can read it. Codes ascend in
  // 4096 steps; the top slot holds the largest code and ohms.
  task automatic test_table_fill();
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i == MAX_POINTS - 1) load_point(4'(i), 16'hFFFF, 32'hFFFF_FFFF);
      else load_point(4'(i), 16'(i * 4096 + 2048), 32'(i) << 24);
    end
  endtask

  task automatic test_directed_conversions();
    // count above the table size acts as the full table
    program_registers(5'd31, 32'h0800_0000);
    convert_code(16'd0);          // below first point, negative -> clamped
    convert_code(16'd2048);       // exactly on the first point
    convert_code(16'd30000);      // interior segment
    convert_code(16'd59393);      // last interior segment
    convert_code(16'hFFFF);       // exactly on the last point
    program_registers(5'd17, 32'h0000_0000);
    convert_code(16'hFFFF);
    // count of zero acts as two points; the code above the last point extrapolates
    program_registers(5'd0, 32'hFFFF_FFFF);
    convert_code(16'hFFFF);
    program_registers(5'd1, 32'hFFFF_FFFF);
    // equal codes on the chosen segment: fault, limit still checked
    load_point(4'd1, 16'd2048, 32'd5);
    convert_code(16'd2048);
    convert_code(16'hFFFF);
    // descending segment, evaluated with a negative divisor
    load_point(4'd1, 16'd1000, 32'hFFFF_FFFF);
    convert_code(16'd1500);
    convert_code(16'd0);
  endtask

  // Receiver holds off while converts keep coming, so a held reading blocks
  // the next convert and the input stalls
  task automatic test_result_backpressure();
    program_registers(5'(MAX_POINTS), $urandom);
    in_idling = 1'b0;
    hold_results_req = 1'b1;
    repeat (24) convert_code(pick_adc_code());
    in_idling = 1'b1;
    wait_idle();
  endtask

  // One setting of the registers, a fresh table and a run of converts with
  // a sprinkling of stray loads
  task automatic run_table_phase();
    logic [15:0] codes [MAX_POINTS];
    logic [31:0] ohms [MAX_POINTS];
    logic [4:0]  count_raw;
    logic [31:0] limit;
    int unsigned n, span, shape, k;
    bit          reverse;
    count_raw = $urandom_range(0, 1) ? 5'($urandom) : 5'($urandom_range(2, MAX_POINTS));
    case ($urandom_range(0, 3))
      0: limit = '0;
      1: limit = '1;
      default: limit = $urandom;
    endcase
    program_registers(count_raw, limit);
    n = points_in_use();
    span = 65536 / n;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      // mostly ascending codes, sometimes arbitrary ones
      if (shape < 8) codes[i] = 16'(i * span + $urandom_range(0, span - 1));
      else codes[i] = 16'($urandom);
      ohms[i] = ($urandom_range(0, 2) == 0) ? 32'(i * 2000 + $urandom_range(0, 1999))
                                            : $urandom;
    end
    if (shape < 3) begin
      codes[0] = '0;
      codes[n-1] = '1;
    end
    // duplicate code on an end segment, where the edge rules pick it
    if (shape == 7) begin
      k = $urandom_range(0, 1) ? 1 : n - 1;
      codes[k] = codes[k-1];
    end
    reverse = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      k = reverse ? n - 1 - i : i;
      load_point(4'(k), codes[k], ohms[k]);
    end
    repeat ($urandom_range(30, 60)) begin
      if ($urandom_range(0, 9) == 0) load_point(4'($urandom), 16'($urandom), $urandom);
      convert_code(pick_adc_code());
    end
  endtask

  task automatic test_random_tables();
    in_idling = 1'b1;
    out_idling = 1'b1;
    while (items_accepted < 720) run_table_phase();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_streaming();
    in_idling = 1'b0;
    out_idling = 1'b0;
    while (items_accepted < 860) run_table_phase();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed_conversions();
    test_result_backpressure();
    test_random_tables();
    test_streaming();
    wait_idle();
    if (failures == 0 && pending_readings.size() == 0) begin
      $display("piecewise_linear_resistance_calibration regression: pass");
    end else begin
      $display("piecewise_linear_resistance_calibration regression: fail");
    end
    $finish;
  end

endmodule
